// ----- hw/rtl/tcp_rtt_sampler_rto_estimator_defines.svh -----
`ifndef TCP_RTT_SAMPLER_RTO_ESTIMATOR_DEFINES_SVH
`define TCP_RTT_SAMPLER_RTO_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RTOEST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RTOEST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rtoest_pkg.sv -----
`default_nettype none

package rtoest_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRANULARITY = 1'b1;

    localparam logic [CFG_DATA_W-1:0] MIN_TIMEOUT_RST = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] GRANULARITY_RST = 16'd100;
    localparam logic [31:0]           TIMEOUT_RST     = 32'd1000;

    typedef enum logic
    {
        OP_SEND = 1'b0,
        OP_ACK  = 1'b1
    } opcode_t;

    typedef struct packed
    {
        opcode_t     opcode;
        logic [31:0] now_ms;
        logic [31:0] segment_first;
        logic [31:0] segment_end;
        logic [31:0] send_frontier;
        logic        resend;
        logic [31:0] acked_number;
        logic [31:0] oldest_unacked;
    } item_t;

    typedef struct packed
    {
        logic        timing_started;
        logic        sample_taken;
        logic [31:0] rtt_sample_ms;
        logic [31:0] smoothed_ms;
        logic [31:0] variation_ms;
        logic [31:0] timeout_ms;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rtoest_item_if.sv -----
`default_nettype none

interface rtoest_item_if;
    import rtoest_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rtoest_result_if.sv -----
`default_nettype none

interface rtoest_result_if;
    import rtoest_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tcp_rtt_sampler_rto_estimator.sv -----
// Channel   Dir  Handshake       Payload
// items     in   valid/ready     send or ack event (item_t)
// results   out  valid/ready     RTT sample and estimator state (result_t)
// cfg       in   cfg_wr_en only  min timeout, clock granularity
//
// One item per cycle while the result output is not stalled.
// Stages: input register, RTT/state update, timeout compute into the output register.
// The estimator state is updated as an item leaves the input register.
// A stalled result holds the pipe stage by stage; empty stages still fill.
// Reset clears estimator state, timeout goes to 1000 ms, config to reset values.
`default_nettype none
`include "tcp_rtt_sampler_rto_estimator_defines.svh"

module tcp_rtt_sampler_rto_estimator
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [rtoest_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtoest_pkg::CFG_DATA_W-1:0] cfg_data,
    rtoest_item_if.sink                      items,
    rtoest_result_if.source                  results
);
    import rtoest_pkg::*;

    typedef struct packed
    {
        logic        started;
        logic        taken;
        logic [31:0] rtt;
        logic [31:0] srtt;
        logic [31:0] spread;
    } stage_t;

    // configuration
    logic [CFG_DATA_W-1:0] min_timeout_reg;
    logic [CFG_DATA_W-1:0] granularity_reg;

    // estimator state
    logic        timing_active_reg, timing_active_next;
    logic [31:0] timed_seq_reg, timed_seq_next;
    logic [31:0] sent_time_reg, sent_time_next;
    logic [31:0] srtt_reg, srtt_next;
    logic [31:0] spread_reg, spread_next;
    logic        awaiting_first_reg, awaiting_first_next;
    logic [31:0] timeout_reg, timeout_next;

    // pipeline
    logic    a_valid_reg;
    item_t   a_item_reg;
    logic    b_valid_reg;
    stage_t  b_reg, b_next;
    logic    out_valid_reg;
    result_t out_reg;

    logic a_adv;
    logic b_free;
    logic out_load;

    // stage A datapath
    logic        start;
    logic        take;
    logic [31:0] rtt;
    logic [32:0] diff_fwd;
    logic [31:0] diff;
    logic [33:0] spread3;
    logic [34:0] srtt7;
    logic [31:0] spread_upd;
    logic [31:0] srtt_upd;

    // stage B datapath
    logic [33:0] spread4;
    logic [33:0] var_floor;
    logic [34:0] rto_sum;
    logic [34:0] rto_low;
    logic [31:0] rto_sat;
    logic [31:0] b_timeout;

    assign out_load    = b_valid_reg && (!out_valid_reg || results.ready);
    assign b_free      = !b_valid_reg || out_load;
    assign a_adv       = a_valid_reg && b_free;
    assign items.ready = !a_valid_reg || a_adv;

    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_timeout_reg <= MIN_TIMEOUT_RST;
            granularity_reg <= GRANULARITY_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MIN_TIMEOUT: min_timeout_reg <= cfg_data;
                REG_GRANULARITY: granularity_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        start = (a_item_reg.opcode == OP_SEND) && !timing_active_reg && !a_item_reg.resend
                && (a_item_reg.segment_first != a_item_reg.segment_end)
                && (a_item_reg.segment_end == a_item_reg.send_frontier);
        take  = (a_item_reg.opcode == OP_ACK)
                && (a_item_reg.acked_number != a_item_reg.oldest_unacked)
                && timing_active_reg && (a_item_reg.acked_number > timed_seq_reg);

        rtt      = a_item_reg.now_ms - sent_time_reg;
        diff_fwd = {1'b0, srtt_reg} - {1'b0, rtt};
        diff     = diff_fwd[32] ? (rtt - srtt_reg) : diff_fwd[31:0];

        // 3/4 and 7/8 terms truncate on their own
        spread3    = {2'b00, spread_reg} + {1'b0, spread_reg, 1'b0};
        srtt7      = {srtt_reg, 3'b000} - {3'b000, srtt_reg};
        spread_upd = spread3[33:2] + {2'b00, diff[31:2]};
        srtt_upd   = srtt7[34:3] + {3'b000, rtt[31:3]};
    end

    always_comb
    begin
        timing_active_next  = timing_active_reg;
        timed_seq_next      = timed_seq_reg;
        sent_time_next      = sent_time_reg;
        srtt_next           = srtt_reg;
        spread_next         = spread_reg;
        awaiting_first_next = awaiting_first_reg;

        if (a_adv && start)
        begin
            timing_active_next = 1'b1;
            timed_seq_next     = a_item_reg.segment_first;
            sent_time_next     = a_item_reg.now_ms;
        end

        if (a_adv && take)
        begin
            timing_active_next  = 1'b0;
            awaiting_first_next = 1'b0;
            if (awaiting_first_reg)
            begin
                srtt_next   = rtt;
                spread_next = {1'b0, rtt[31:1]};
            end
            else
            begin
                srtt_next   = srtt_upd;
                spread_next = spread_upd;
            end
        end

        b_next.started = start;
        b_next.taken   = take;
        b_next.rtt     = take ? rtt : 32'd0;
        b_next.srtt    = srtt_next;
        b_next.spread  = spread_next;
    end

    always_comb
    begin
        spread4   = {b_reg.spread, 2'b00};
        var_floor = (spread4 > {18'd0, granularity_reg}) ? spread4 : {18'd0, granularity_reg};
        rto_sum   = {3'b000, b_reg.srtt} + {1'b0, var_floor};
        rto_low   = (rto_sum > {19'd0, min_timeout_reg}) ? rto_sum : {19'd0, min_timeout_reg};
        rto_sat   = (|rto_low[34:32]) ? 32'hFFFF_FFFF : rto_low[31:0];
        b_timeout = b_reg.taken ? rto_sat : timeout_reg;

        timeout_next = out_load ? b_timeout : timeout_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_active_reg  <= 1'b0;
            timed_seq_reg      <= 32'd0;
            sent_time_reg      <= 32'd0;
            srtt_reg           <= 32'd0;
            spread_reg         <= 32'd0;
            awaiting_first_reg <= 1'b1;
            timeout_reg        <= TIMEOUT_RST;
            a_valid_reg        <= 1'b0;
            b_valid_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            timing_active_reg  <= timing_active_next;
            timed_seq_reg      <= timed_seq_next;
            sent_time_reg      <= sent_time_next;
            srtt_reg           <= srtt_next;
            spread_reg         <= spread_next;
            awaiting_first_reg <= awaiting_first_next;
            timeout_reg        <= timeout_next;
            if (items.ready)
            begin
                a_valid_reg <= items.valid;
            end
            if (b_free)
            begin
                b_valid_reg <= a_adv;
            end
            if (!out_valid_reg || results.ready)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            a_item_reg <= items.data;
        end
        if (a_adv)
        begin
            b_reg <= b_next;
        end
        if (out_load)
        begin
            out_reg.timing_started <= b_reg.started;
            out_reg.sample_taken   <= b_reg.taken;
            out_reg.rtt_sample_ms  <= b_reg.rtt;
            out_reg.smoothed_ms    <= b_reg.srtt;
            out_reg.variation_ms   <= b_reg.spread;
            out_reg.timeout_ms     <= b_timeout;
        end
    end

    // a measurement only ends through a sample
    `RTOEST_ASSERT_NOW(a_timing_ends_on_sample, $fell(timing_active_reg),
        $past(a_adv && take), "timing ended without a sample")

    // first sample leaves the variation at half the smoothed RTT
    `RTOEST_ASSERT_NOW(a_first_sample_half, $fell(awaiting_first_reg),
        spread_reg == {1'b0, srtt_reg[31:1]}, "first sample variation mismatch")

    // the presented timeout always tracks the stored timeout
    `RTOEST_ASSERT_NEXT(a_timeout_tracks, out_load,
        results.data.timeout_ms == timeout_reg, "result timeout differs from state")

endmodule

`default_nettype wire
